### rtl/core/hs7_pkg.sv
// shared constants and types for the 7-point 3d heat stencil core
`default_nettype none

package hs7_pkg;

   // fixed field widths
   localparam int DATA_W     = 32;
   localparam int COEF_W     = 16;
   localparam int SIZE_XY_W  = 7;
   localparam int SIZE_Z_W   = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // default grid bounds
   localparam int DEF_MAX_X = 64;
   localparam int DEF_MAX_Y = 64;
   localparam int DEF_MAX_Z = 1024;

   // register reset values
   localparam logic [SIZE_XY_W-1:0] RST_SIZE_XY = SIZE_XY_W'(64);
   localparam logic [SIZE_Z_W-1:0]  RST_SIZE_Z  = SIZE_Z_W'(64);
   localparam logic [COEF_W-1:0]    RST_COEF    = COEF_W'(10923);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_Z = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_X = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_Y = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_Z = 3'd5;

   // input operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   // stencil arithmetic widths
   localparam int DIFF_W = DATA_W + 2;
   localparam int PROD_W = DIFF_W + COEF_W + 1;
   localparam int ACC_W  = PROD_W + 2;

   // plane memory word: older plane above current plane
   typedef struct packed {
      logic [DATA_W-1:0] plane2;
      logic [DATA_W-1:0] plane1;
   } plane_word_type;

   // row memory word: look-ahead row values delayed by one and two rows, plus the older-plane look-ahead value
   typedef struct packed {
      logic [DATA_W-1:0] row1;
      logic [DATA_W-1:0] row2;
      logic [DATA_W-1:0] back1;
   } row_word_type;

   // one result transaction
   typedef struct packed {
      logic              last;
      logic [DATA_W-1:0] value;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/heat_stencil_7pt_3d_core.sv
// 7-point 3d heat stencil core: one explicit time step on a raster-streamed grid
`default_nettype none

// channel  | direction | payload
// req      | in        | tdata: sample_value[31:0]; tuser: operation[0]
// rsp      | out       | tdata: new_value[31:0]; tlast: grid_last
// csr      | in        | csr_addr selects register, csr_wdata is the value
//
// one transaction per cycle sustained while req_tready is high; results pass through the stage registers and the queue.
// the plane memory is read once per cycle and written once per accepted sample (look-ahead read, current cell write).
// req_tready drops while 8 results are queued or in flight in the pipeline.
// synchronous reset clears counters and pipeline valids and loads register reset values; memories are not cleared.
// rsp stalls only back up into the 8-entry result queue.

module heat_stencil_7pt_3d_core #(
   parameter int MAX_X = hs7_pkg::DEF_MAX_X,
   parameter int MAX_Y = hs7_pkg::DEF_MAX_Y,
   parameter int MAX_Z = hs7_pkg::DEF_MAX_Z
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [hs7_pkg::DATA_W-1:0]       req_tdata,   // [31:0] sample_value
   input  wire  [0:0]                       req_tuser,   // [0] operation
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [hs7_pkg::DATA_W-1:0]       rsp_tdata,   // [31:0] new_value
   output logic                             rsp_tlast,
   input  wire                              csr_we,
   input  wire  [hs7_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire  [hs7_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DW   = hs7_pkg::DATA_W;
   localparam int XC   = $clog2(MAX_X + 1);
   localparam int YC   = $clog2(MAX_Y + 1);
   localparam int ZC   = $clog2(MAX_Z + 1);
   localparam int XI   = $clog2(MAX_X);
   localparam int YI   = $clog2(MAX_Y);
   localparam int ZI   = $clog2(MAX_Z);
   localparam int PD   = MAX_X * MAX_Y;
   localparam int PC   = $clog2(PD + 1);
   localparam int PI   = $clog2(PD);
   localparam int FIFO_DEPTH = 8;
   localparam int FP   = $clog2(FIFO_DEPTH);
   localparam int FC   = $clog2(FIFO_DEPTH + 1);
   localparam int CW   = FC + 1;
   localparam logic signed [hs7_pkg::ACC_W-1:0] ROUND_HALF = hs7_pkg::ACC_W'(32768);
   localparam logic signed [hs7_pkg::ACC_W-17:0] SAT_HI =
      (hs7_pkg::ACC_W-16)'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [hs7_pkg::ACC_W-17:0] SAT_LO =
      -(hs7_pkg::ACC_W-16)'({1'b0, {(DW-1){1'b1}}}) - (hs7_pkg::ACC_W-16)'(1);

   // configuration registers
   logic [hs7_pkg::SIZE_XY_W-1:0] cfg_x_ff, cfg_y_ff;
   logic [hs7_pkg::SIZE_Z_W-1:0]  cfg_z_ff;
   logic [hs7_pkg::COEF_W-1:0]    coef_x_ff, coef_y_ff, coef_z_ff;
   logic                          csr_hit;

   // clamped sizes
   logic [XC-1:0] nx_ff, nx_in;
   logic [YC-1:0] ny_ff, ny_in;
   logic [ZC-1:0] nz_ff, nz_in;
   logic [PC-1:0] xy_ff, xy_in;

   // grid position counters
   logic [XI-1:0] in_i_ff, in_i_in;
   logic [YI-1:0] in_j_ff, in_j_in;
   logic [ZI-1:0] in_k_ff, in_k_in;
   logic [PI-1:0] in_pos_ff, in_pos_in;
   logic          in_done_ff, in_done_in;
   logic [PI-1:0] out_pos_ff, out_pos_in;
   logic [ZI-1:0] out_k_ff, out_k_in;

   // accept stage
   logic          acc_in, is_drain, smp_ok, smp_emit, drn_emit, emit0, last0, face0;
   logic [PI:0]   ahead_sum;
   logic [PI-1:0] ahead_pos, m1_raddr;
   logic [XI-1:0] xi_next;
   logic          fwd0;

   // memories
   hs7_pkg::plane_word_type m1_ram [PD];
   hs7_pkg::row_word_type   m2_ram [MAX_X];
   hs7_pkg::plane_word_type m1_rd_ff, m1_wdata;
   hs7_pkg::row_word_type   m2a_rd_ff, m2b_rd_ff, m2_wdata;

   // stage 1
   logic          s1_smp_ff, s1_emit_ff, s1_drain_ff, s1_face_ff, s1_last_ff, s1_fwd_ff;
   logic [DW-1:0] s1_val_ff, s1_fwd_data_ff, prev_center_ff;
   logic [PI-1:0] s1_wpos_ff;
   logic [XI-1:0] s1_xi_ff;
   logic [DW-1:0] u_c, u_o;
   logic signed [hs7_pkg::DIFF_W-1:0] dx_in, dy_in, dz_in;

   // stages 2 to 4
   logic          s2_v_ff, s2_face_ff, s2_last_ff;
   logic [DW-1:0] s2_o_ff;
   logic signed [hs7_pkg::DIFF_W-1:0] s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic          s3_v_ff, s3_face_ff, s3_last_ff;
   logic [DW-1:0] s3_o_ff;
   logic signed [hs7_pkg::PROD_W-1:0] s3_px_ff, s3_py_ff, s3_pz_ff, px_in, py_in, pz_in;
   logic          s4_v_ff, s4_face_ff, s4_last_ff;
   logic [DW-1:0] s4_o_ff;
   logic signed [hs7_pkg::ACC_W-1:0]  s4_acc_ff, acc_sum_in;
   logic signed [hs7_pkg::ACC_W-17:0] q_val;
   hs7_pkg::result_type res_in;

   // result queue
   hs7_pkg::result_type fifo_ff [FIFO_DEPTH];
   logic [FP-1:0] fifo_wp_ff, fifo_rp_ff;
   logic [FC-1:0] fifo_cnt_ff;
   logic          push, pop;
   logic [CW-1:0] credit;

   // register write decode
   assign csr_hit = csr_we && (csr_addr == hs7_pkg::CSR_GRID_X || csr_addr == hs7_pkg::CSR_GRID_Y
      || csr_addr == hs7_pkg::CSR_GRID_Z || csr_addr == hs7_pkg::CSR_COEF_X
      || csr_addr == hs7_pkg::CSR_COEF_Y || csr_addr == hs7_pkg::CSR_COEF_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_x_ff  <= hs7_pkg::RST_SIZE_XY;
         cfg_y_ff  <= hs7_pkg::RST_SIZE_XY;
         cfg_z_ff  <= hs7_pkg::RST_SIZE_Z;
         coef_x_ff <= hs7_pkg::RST_COEF;
         coef_y_ff <= hs7_pkg::RST_COEF;
         coef_z_ff <= hs7_pkg::RST_COEF;
      end else if (csr_we) begin
         unique case (csr_addr)
            hs7_pkg::CSR_GRID_X: cfg_x_ff  <= csr_wdata[hs7_pkg::SIZE_XY_W-1:0];
            hs7_pkg::CSR_GRID_Y: cfg_y_ff  <= csr_wdata[hs7_pkg::SIZE_XY_W-1:0];
            hs7_pkg::CSR_GRID_Z: cfg_z_ff  <= csr_wdata[hs7_pkg::SIZE_Z_W-1:0];
            hs7_pkg::CSR_COEF_X: coef_x_ff <= csr_wdata;
            hs7_pkg::CSR_COEF_Y: coef_y_ff <= csr_wdata;
            hs7_pkg::CSR_COEF_Z: coef_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // size clamping and plane size
   always_comb begin
      if (32'(cfg_x_ff) < 32'd3)         nx_in = XC'(3);
      else if (32'(cfg_x_ff) > MAX_X)   nx_in = XC'(MAX_X);
      else                              nx_in = XC'(cfg_x_ff);
      if (32'(cfg_y_ff) < 32'd3)         ny_in = YC'(3);
      else if (32'(cfg_y_ff) > MAX_Y)   ny_in = YC'(MAX_Y);
      else                              ny_in = YC'(cfg_y_ff);
      if (32'(cfg_z_ff) < 32'd3)         nz_in = ZC'(3);
      else if (32'(cfg_z_ff) > MAX_Z)   nz_in = ZC'(MAX_Z);
      else                              nz_in = ZC'(cfg_z_ff);
      xy_in = PC'((XC+YC)'(nx_ff) * (XC+YC)'(ny_ff));
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      nz_ff <= nz_in;
      xy_ff <= xy_in;
   end

   // accept stage decode
   assign credit     = CW'(fifo_cnt_ff) + CW'(s1_emit_ff) + CW'(s2_v_ff) + CW'(s3_v_ff)
                       + CW'(s4_v_ff);
   assign req_tready = credit < CW'(FIFO_DEPTH);
   assign acc_in     = req_tvalid && req_tready;
   assign is_drain   = req_tuser[0] == hs7_pkg::OP_DRAIN;
   assign smp_ok     = acc_in && !is_drain && !in_done_ff;
   assign smp_emit   = smp_ok && (in_k_ff != '0);
   assign drn_emit   = acc_in && is_drain && in_done_ff;
   assign emit0      = smp_emit || drn_emit;
   assign last0      = drn_emit && (ZC'(out_k_ff) == nz_ff - ZC'(1))
                       && (PC'(out_pos_ff) == xy_ff - PC'(1));
   assign face0      = (in_i_ff == '0) || (XC'(in_i_ff) == nx_ff - XC'(1))
                       || (in_j_ff == '0) || (YC'(in_j_ff) == ny_ff - YC'(1))
                       || (in_k_ff == ZI'(1));

   // look-ahead row address in the plane ring
   assign ahead_sum = (PI+1)'(in_pos_ff) + (PI+1)'(nx_ff);
   assign ahead_pos = ((PC+1)'(ahead_sum) >= (PC+1)'(xy_ff))
                      ? PI'((PC+1)'(ahead_sum) - (PC+1)'(xy_ff)) : PI'(ahead_sum);
   assign m1_raddr  = is_drain ? out_pos_ff : ahead_pos;
   assign xi_next   = (XC'(in_i_ff) == nx_ff - XC'(1)) ? '0 : in_i_ff + XI'(1);
   assign fwd0      = is_drain && s1_smp_ff && (s1_wpos_ff == out_pos_ff);

   // counter next state
   always_comb begin
      in_i_in    = in_i_ff;
      in_j_in    = in_j_ff;
      in_k_in    = in_k_ff;
      in_pos_in  = in_pos_ff;
      in_done_in = in_done_ff;
      out_pos_in = out_pos_ff;
      out_k_in   = out_k_ff;
      priority if (csr_hit || last0) begin
         in_i_in    = '0;
         in_j_in    = '0;
         in_k_in    = '0;
         in_pos_in  = '0;
         in_done_in = 1'b0;
         out_pos_in = '0;
         out_k_in   = '0;
      end else begin
         if (smp_ok) begin
            in_pos_in = (PC'(in_pos_ff) == xy_ff - PC'(1)) ? '0 : in_pos_ff + PI'(1);
            if (XC'(in_i_ff) == nx_ff - XC'(1)) begin
               in_i_in = '0;
               if (YC'(in_j_ff) == ny_ff - YC'(1)) begin
                  in_j_in = '0;
                  if (ZC'(in_k_ff) == nz_ff - ZC'(1)) in_done_in = 1'b1;
                  else                                in_k_in = in_k_ff + ZI'(1);
               end else begin
                  in_j_in = in_j_ff + YI'(1);
               end
            end else begin
               in_i_in = in_i_ff + XI'(1);
            end
         end
         if (emit0) begin
            if (PC'(out_pos_ff) == xy_ff - PC'(1)) begin
               out_pos_in = '0;
               out_k_in   = out_k_ff + ZI'(1);
            end else begin
               out_pos_in = out_pos_ff + PI'(1);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_i_ff     <= '0;
         in_j_ff     <= '0;
         in_k_ff     <= '0;
         in_pos_ff   <= '0;
         in_done_ff  <= 1'b0;
         out_pos_ff  <= '0;
         out_k_ff    <= '0;
         s1_smp_ff   <= 1'b0;
         s1_emit_ff  <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
         fifo_wp_ff  <= '0;
         fifo_rp_ff  <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         in_i_ff     <= in_i_in;
         in_j_ff     <= in_j_in;
         in_k_ff     <= in_k_in;
         in_pos_ff   <= in_pos_in;
         in_done_ff  <= in_done_in;
         out_pos_ff  <= out_pos_in;
         out_k_ff    <= out_k_in;
         s1_smp_ff   <= smp_ok;
         s1_emit_ff  <= emit0;
         s2_v_ff     <= s1_emit_ff;
         s3_v_ff     <= s2_v_ff;
         s4_v_ff     <= s3_v_ff;
         if (push) fifo_wp_ff <= fifo_wp_ff + FP'(1);
         if (pop)  fifo_rp_ff <= fifo_rp_ff + FP'(1);
         fifo_cnt_ff <= fifo_cnt_ff + FC'(push) - FC'(pop);
      end
   end

   // plane ring memory: read look-ahead or drain cell, write current column
   always_ff @(posedge clock) begin
      if (s1_smp_ff) m1_ram[s1_wpos_ff] <= m1_wdata;
      m1_rd_ff <= m1_ram[m1_raddr];
   end

   // row delay memory: read at x and x+1, write back at x
   always_ff @(posedge clock) begin
      if (s1_smp_ff) m2_ram[s1_xi_ff] <= m2_wdata;
      m2a_rd_ff <= m2_ram[in_i_ff];
      m2b_rd_ff <= m2_ram[xi_next];
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      s1_drain_ff    <= is_drain;
      s1_face_ff     <= drn_emit || face0;
      s1_last_ff     <= last0;
      s1_val_ff      <= req_tdata;
      s1_wpos_ff     <= in_pos_ff;
      s1_xi_ff       <= in_i_ff;
      s1_fwd_ff      <= fwd0;
      s1_fwd_data_ff <= s1_val_ff;
      if (s1_smp_ff) prev_center_ff <= u_c;
   end

   // stencil taps and second differences
   always_comb begin
      u_c = m2a_rd_ff.row1;
      if (s1_drain_ff) u_o = s1_fwd_ff ? s1_fwd_data_ff : m1_rd_ff.plane1;
      else             u_o = u_c;
      m1_wdata.plane1 = s1_val_ff;
      m1_wdata.plane2 = u_c;
      m2_wdata.row1   = m1_rd_ff.plane1;
      m2_wdata.row2   = u_c;
      m2_wdata.back1  = m1_rd_ff.plane2;
      dx_in = hs7_pkg::DIFF_W'($signed(m2b_rd_ff.row1)) + hs7_pkg::DIFF_W'($signed(prev_center_ff))
              - (hs7_pkg::DIFF_W'($signed(u_c)) <<< 1);
      dy_in = hs7_pkg::DIFF_W'($signed(m1_rd_ff.plane1)) + hs7_pkg::DIFF_W'($signed(m2a_rd_ff.row2))
              - (hs7_pkg::DIFF_W'($signed(u_c)) <<< 1);
      dz_in = hs7_pkg::DIFF_W'($signed(s1_val_ff)) + hs7_pkg::DIFF_W'($signed(m2a_rd_ff.back1))
              - (hs7_pkg::DIFF_W'($signed(u_c)) <<< 1);
   end

   // coefficient products
   assign px_in = s2_dx_ff * $signed({1'b0, coef_x_ff});
   assign py_in = s2_dy_ff * $signed({1'b0, coef_y_ff});
   assign pz_in = s2_dz_ff * $signed({1'b0, coef_z_ff});

   // q.16 sum with half-up rounding
   assign acc_sum_in = hs7_pkg::ACC_W'($signed({s3_o_ff, 16'h0000})) + hs7_pkg::ACC_W'(s3_px_ff)
                       + hs7_pkg::ACC_W'(s3_py_ff) + hs7_pkg::ACC_W'(s3_pz_ff) + ROUND_HALF;

   always_ff @(posedge clock) begin
      s2_face_ff <= s1_face_ff;
      s2_last_ff <= s1_last_ff;
      s2_o_ff    <= u_o;
      s2_dx_ff   <= dx_in;
      s2_dy_ff   <= dy_in;
      s2_dz_ff   <= dz_in;
      s3_face_ff <= s2_face_ff;
      s3_last_ff <= s2_last_ff;
      s3_o_ff    <= s2_o_ff;
      s3_px_ff   <= px_in;
      s3_py_ff   <= py_in;
      s3_pz_ff   <= pz_in;
      s4_face_ff <= s3_face_ff;
      s4_last_ff <= s3_last_ff;
      s4_o_ff    <= s3_o_ff;
      s4_acc_ff  <= acc_sum_in;
   end

   // floor by 2^16 and saturate; face cells pass the old value through
   always_comb begin
      q_val      = s4_acc_ff[hs7_pkg::ACC_W-1:16];
      res_in.last = s4_last_ff;
      if (s4_face_ff)          res_in.value = s4_o_ff;
      else if (q_val > SAT_HI) res_in.value = {1'b0, {(DW-1){1'b1}}};
      else if (q_val < SAT_LO) res_in.value = {1'b1, {(DW-1){1'b0}}};
      else                     res_in.value = q_val[DW-1:0];
   end

   // result queue
   assign push = s4_v_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (push) fifo_ff[fifo_wp_ff] <= res_in;
   end

   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_tdata  = fifo_ff[fifo_rp_ff].value;
   assign rsp_tlast  = fifo_ff[fifo_rp_ff].last;

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (fifo_cnt_ff < FC'(FIFO_DEPTH)))
      else $error("result queue overflow");

   a_done_wrapped: assert property (@(posedge clock) disable iff (reset)
      in_done_ff |-> (in_i_ff == '0 && in_j_ff == '0))
      else $error("grid complete with x or y counter not wrapped");

   a_fwd_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_emit_ff && s1_fwd_ff) |-> s1_drain_ff)
      else $error("plane forwarding used outside a drain transaction");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      acc_in |=> (credit <= CW'(FIFO_DEPTH)))
      else $error("results in flight exceed queue space");

endmodule

`default_nettype wire

### sim/tb_heat_stencil_7pt_3d_core.sv
// testbench for the 7-point 3d heat stencil core: random grids checked against a predictor
`default_nettype none

import hs7_pkg::*;

// predicts every stencil result and checks results in order
class heat_step_scoreboard;
   localparam int WIN_DEPTH = 2 * DEF_MAX_X * DEF_MAX_Y + 1;

   logic signed [DATA_W-1:0] win [WIN_DEPTH];
   int unsigned in_pos, out_pos;
   logic [SIZE_XY_W-1:0] size_x, size_y;
   logic [SIZE_Z_W-1:0]  size_z;
   logic [COEF_W-1:0]    cx, cy, cz;
   logic [DATA_W-1:0]    exp_value [$];
   logic                 exp_last [$];
   int                   errors;

   function new();
      foreach (win[n]) win[n] = '0;
      in_pos  = 0;
      out_pos = 0;
      size_x  = RST_SIZE_XY;
      size_y  = RST_SIZE_XY;
      size_z  = RST_SIZE_Z;
      cx      = RST_COEF;
      cy      = RST_COEF;
      cz      = RST_COEF;
      errors  = 0;
   endfunction

   function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function longint tap(int unsigned p);
      return longint'(win[p % WIN_DEPTH]);
   endfunction

   // register write: any known index restarts the grid
   function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      case (addr)
         CSR_GRID_X: size_x = data[SIZE_XY_W-1:0];
         CSR_GRID_Y: size_y = data[SIZE_XY_W-1:0];
         CSR_GRID_Z: size_z = data[SIZE_Z_W-1:0];
         CSR_COEF_X: cx = data;
         CSR_COEF_Y: cy = data;
         CSR_COEF_Z: cz = data;
         default: return;
      endcase
      in_pos  = 0;
      out_pos = 0;
   endfunction

   // new temperature of the cell at raster position p
   function logic [DATA_W-1:0] predict_cell(int unsigned p, int unsigned nx,
                                             int unsigned ny, int unsigned nz);
      int unsigned xy, i, j, k;
      longint o, dx, dy, dz, acc, q;
      xy = nx * ny;
      i  = p % nx;
      j  = (p / nx) % ny;
      k  = p / xy;
      o  = tap(p);
      // faces pass through
      if (i == 0 || i >= nx - 1 || j == 0 || j >= ny - 1 || k == 0 || k >= nz - 1)
         return o[DATA_W-1:0];
      dx  = tap(p + 1) - 2 * o + tap(p - 1);
      dy  = tap(p + nx) - 2 * o + tap(p - nx);
      dz  = tap(p + xy) - 2 * o + tap(p - xy);
      acc = o * 65536 + longint'(cx) * dx + longint'(cy) * dy + longint'(cz) * dz + 32768;
      q   = acc >>> 16;
      // saturate to 32 bits
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[DATA_W-1:0];
   endfunction

   // accepted input transaction
   function void note_input(logic op, logic [DATA_W-1:0] val);
      int unsigned nx, ny, nz, xy, total;
      bit emit;
      nx    = clamp(size_x, DEF_MAX_X);
      ny    = clamp(size_y, DEF_MAX_Y);
      nz    = clamp(size_z, DEF_MAX_Z);
      xy    = nx * ny;
      total = xy * nz;
      emit  = 0;
      if (op == OP_SAMPLE) begin
         if (in_pos >= total) return;
         win[in_pos % WIN_DEPTH] = val;
         in_pos++;
         emit = (in_pos > out_pos + xy);
      end else begin
         emit = (in_pos == total && out_pos < total);
      end
      if (!emit) return;
      exp_value.push_back(predict_cell(out_pos, nx, ny, nz));
      exp_last.push_back(out_pos == total - 1);
      out_pos++;
      if (out_pos >= total) begin
         in_pos  = 0;
         out_pos = 0;
      end
   endfunction

   // accepted result transaction
   function void check_result(logic [DATA_W-1:0] value, logic last);
      logic [DATA_W-1:0] ev;
      logic el;
      if (exp_value.size() == 0) begin
         $error("unexpected result: new_value %h grid_last %b", value, last);
         errors++;
         return;
      end
      ev = exp_value.pop_front();
      el = exp_last.pop_front();
      if (value !== ev) begin
         $error("new_value mismatch: expected %h actual %h", ev, value);
         errors++;
      end
      if (last !== el) begin
         $error("grid_last mismatch: expected %b actual %b", el, last);
         errors++;
      end
   endfunction

   function int pending();
      return exp_value.size();
   endfunction
endclass

module tb_heat_stencil_7pt_3d_core;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int RESULT_LATENCY = 5;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle = 26;
   int recv_idle = 65;
   int grid_items = 0;
   int value_mode = 0;

   heat_step_scoreboard sb = new();

   heat_stencil_7pt_3d_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // transaction monitors
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_input(req_tuser[0], req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   task automatic send_item(logic op, logic [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
   endtask

   // csr_we is lowered by the caller after a batch of writes
   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(addr, data);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (RESULT_LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case (value_mode)
         0: return $urandom;
         1: return DATA_W'($signed($urandom_range(2097151)) - 1048576);
         default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic configure(int nx, int ny, int nz);
      write_reg(CSR_GRID_X, CSR_DATA_W'(nx));
      write_reg(CSR_GRID_Y, CSR_DATA_W'(ny));
      write_reg(CSR_GRID_Z, CSR_DATA_W'(nz));
      write_reg(CSR_COEF_X, pick_coef());
      write_reg(CSR_COEF_Y, pick_coef());
      write_reg(CSR_COEF_Z, pick_coef());
      csr_we <= 1'b0;
   endtask

   // full grid with a sprinkling of early drains, then the flush
   task automatic run_grid(int cells, int plane);
      for (int c = 0; c < cells; c++) begin
         if ($urandom_range(24) == 0) send_item(OP_DRAIN, $urandom);
         send_item(OP_SAMPLE, pick_value());
         grid_items++;
      end
      if ($urandom_range(3) == 0) send_item(OP_SAMPLE, $urandom);
      for (int c = 0; c < plane; c++) begin
         send_item(OP_DRAIN, $urandom);
         grid_items++;
      end
      if ($urandom_range(3) == 0) send_item(OP_DRAIN, $urandom);
   endtask

   initial begin
      int nx, ny, nz;
      int cx, cy, cz;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: smallest grid, coefficient extremes, saturation, ignored items
      write_reg(CSR_GRID_X, 16'd3);
      write_reg(CSR_GRID_Y, 16'd3);
      write_reg(CSR_GRID_Z, 16'd3);
      write_reg(CSR_COEF_X, 16'd0);
      write_reg(CSR_COEF_Y, 16'hffff);
      write_reg(CSR_COEF_Z, 16'h8000);
      csr_we <= 1'b0;
      send_item(OP_DRAIN, 32'hffff_ffff);
      for (int c = 0; c < 3; c++) send_item(OP_SAMPLE, 32'h8000_0000);
      // unknown indexes must not restart the grid
      wait_idle();
      write_reg(CSR_SPARE_6, 16'hffff);
      write_reg(CSR_SPARE_7, 16'h0001);
      csr_we <= 1'b0;
      for (int c = 3; c < 27; c++)
         send_item(OP_SAMPLE, (c == 13) ? 32'h7fff_ffff : 32'h8000_0000);
      send_item(OP_SAMPLE, 32'h1234_5678);
      for (int c = 0; c < 9; c++) send_item(OP_DRAIN, 32'h0);
      send_item(OP_DRAIN, 32'h0);

      // size clamping: oversize and undersize writes, junk above the field
      value_mode = 1;
      wait_idle();
      configure(127, 3, 3);
      run_grid(64 * 9, 64 * 3);
      wait_idle();
      configure(3, 16'hff00 | 100, 0);
      run_grid(64 * 9, 64 * 3);
      wait_idle();
      configure(0, 1, 2);
      run_grid(27, 9);
      wait_idle();
      configure(3, 3, 2047);
      run_grid(9 * 1024, 9);

      // random grids through three idle phases
      grid_items = 0;
      while (grid_items < 1850) begin
         if (grid_items < 617) begin
            send_idle = 26;
            recv_idle = 65;
         end else if (grid_items < 1234) begin
            send_idle = 65;
            recv_idle = 26;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         value_mode = $urandom_range(2);
         nx = $urandom_range(6, 3);
         ny = $urandom_range(6, 3);
         nz = $urandom_range(5, 3);
         wait_idle();
         configure(($urandom_range(511) << 7) | nx, ny, nz);
         if ($urandom_range(7) == 0) begin
            // abandoned grid: stop before any result is due
            for (int c = $urandom_range(nx * ny - 1, 1); c > 0; c--) begin
               send_item(OP_SAMPLE, pick_value());
               grid_items++;
            end
         end else begin
            run_grid(nx * ny * nz, nx * ny);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

`default_nettype wire
